>>> sv/lbs_pkg.sv
package lbs_pkg;

    localparam int PSIZE_BITS    = 16;
    localparam int AMOUNT_BITS   = 16;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BUCKET_CAPACITY = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEAK_RATE       = 8'd1;

    localparam logic [CFG_DATA_BITS-1:0] CAPACITY_RESET  = 16'd1024;
    localparam logic [CFG_DATA_BITS-1:0] LEAK_RATE_RESET = 16'd64;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_DROP   = 2'd1,
        KIND_SENT   = 2'd2,
        KIND_FLUSH  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STAT,
        ST_RD,
        ST_EVAL
    } t_state;

endpackage

>>> sv/lbs_if.sv
interface lbs_in_if import lbs_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [PSIZE_BITS-1:0] packet_size;

    modport source (output valid, output mode, output packet_size, input ready);
    modport sink   (input valid, input mode, input packet_size, output ready);
endinterface

interface lbs_out_if import lbs_pkg::*; ;
    logic                   valid;
    logic                   ready;
    t_kind                  kind;
    logic [AMOUNT_BITS-1:0] amount;
    logic                   last;

    modport source (output valid, output kind, output amount, output last, input ready);
    modport sink   (input valid, input kind, input amount, input last, output ready);
endinterface

interface lbs_cfg_if import lbs_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/leaky_bucket_shaper_top.sv
// Leaky bucket shaper over a queue of packet sizes held in one synchronous
// memory of QUEUE_DEPTH entries. Each input (arrival or flush) yields a status
// transaction first, then one sent transaction per drained or partly drained
// head packet; last marks the final transaction of the input. An input is
// accepted in ST_IDLE, then passes a status state, then a memory read and an
// evaluate state per head packet through the single read port; the status and
// evaluate states wait while the output side stalls. The next input is taken
// once the previous one has produced its final transaction into the output
// register. No clearing pass is needed after reset: only occupied entries are
// read. Configuration writes are taken at any time and must only be made while
// no input is in progress.
module leaky_bucket_shaper_top import lbs_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int SIZE_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lbs_in_if.sink    i_in,
    lbs_out_if.source o_out,
    lbs_cfg_if.sink   i_cfg
);

    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW   = (SIZE_BITS > CFG_DATA_BITS) ? SIZE_BITS : CFG_DATA_BITS;
    localparam int CW   = LW + 1;

    t_state                   r_state, n_state;
    logic [CFG_DATA_BITS-1:0] r_capacity;
    logic [CFG_DATA_BITS-1:0] r_leak_rate;
    logic                     r_mode;
    logic [SIZE_BITS-1:0]     r_psize;
    logic [CFG_DATA_BITS-1:0] r_left, n_left;
    logic [PW-1:0]            r_head, n_head;
    logic [PW-1:0]            r_tail, n_tail;
    logic [CNTW-1:0]          r_count, n_count;
    logic [SIZE_BITS-1:0]     r_total, n_total;
    logic                     r_ovalid, n_ovalid;
    t_kind                    r_okind, n_okind;
    logic [AMOUNT_BITS-1:0]   r_oamount, n_oamount;
    logic                     r_olast, n_olast;

    logic [SIZE_BITS-1:0]     mem [QUEUE_DEPTH];
    logic [SIZE_BITS-1:0]     r_rdata;

    logic                     we;
    logic [PW-1:0]            waddr;
    logic [SIZE_BITS-1:0]     wdata;
    logic                     rd_en;

    logic                     in_accept;
    logic                     out_free;
    logic                     emit;
    logic [CW-1:0]            sum;
    logic                     full;
    logic                     drop;
    logic                     fits;
    logic [PW-1:0]            head_next;
    logic [PW-1:0]            tail_next;
    logic [CFG_DATA_BITS-1:0] left_after;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid  = r_ovalid;
    assign o_out.kind   = r_okind;
    assign o_out.amount = r_oamount;
    assign o_out.last   = r_olast;

    assign out_free  = !r_ovalid || o_out.ready;
    assign head_next = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign sum       = CW'(r_total) + CW'(r_psize);
    assign full      = (r_count == CNTW'(QUEUE_DEPTH));
    assign drop      = (sum > CW'(r_capacity)) || full;
    assign fits      = LW'(r_rdata) <= LW'(r_left);
    assign left_after = r_left - CFG_DATA_BITS'(r_rdata);

    always_comb begin
        n_state   = r_state;
        n_left    = r_left;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_total   = r_total;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_okind   = r_okind;
        n_oamount = r_oamount;
        n_olast   = r_olast;
        we        = 1'b0;
        waddr     = r_tail;
        wdata     = r_psize;
        rd_en     = 1'b0;
        emit      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_STAT;
                end
            end
            ST_STAT: begin
                if (out_free) begin
                    emit     = 1'b1;
                    n_ovalid = 1'b1;
                    if (r_mode) begin
                        n_okind   = KIND_FLUSH;
                        n_oamount = '0;
                        n_olast   = (r_count == '0);
                        if (r_count == '0) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_total = '0;
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_RD;
                        end
                    end else begin
                        n_oamount = AMOUNT_BITS'(r_psize);
                        if (drop) begin
                            n_okind = KIND_DROP;
                            n_olast = (r_count == '0) || (r_left == '0);
                        end else begin
                            n_okind = KIND_ACCEPT;
                            n_olast = (r_left == '0);
                            we      = 1'b1;
                            n_tail  = tail_next;
                            n_count = r_count + 1'b1;
                            n_total = SIZE_BITS'(sum);
                        end
                        n_state = n_olast ? ST_IDLE : ST_RD;
                    end
                end
            end
            ST_RD: begin
                rd_en   = 1'b1;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (out_free) begin
                    emit     = 1'b1;
                    n_ovalid = 1'b1;
                    n_okind  = KIND_SENT;
                    if (r_mode) begin
                        n_oamount = AMOUNT_BITS'(r_rdata);
                        n_olast   = (r_count == CNTW'(1));
                        if (n_olast) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_total = '0;
                            n_state = ST_IDLE;
                        end else begin
                            n_head  = head_next;
                            n_count = r_count - 1'b1;
                            n_state = ST_RD;
                        end
                    end else if (fits) begin
                        n_oamount = AMOUNT_BITS'(r_rdata);
                        n_left    = left_after;
                        n_total   = (r_total >= r_rdata) ? r_total - r_rdata : '0;
                        n_head    = head_next;
                        n_count   = r_count - 1'b1;
                        n_olast   = (r_count == CNTW'(1)) || (left_after == '0);
                        n_state   = n_olast ? ST_IDLE : ST_RD;
                    end else begin
                        // head larger than the allowance: shrink it in place
                        n_oamount = AMOUNT_BITS'(r_left);
                        we        = 1'b1;
                        waddr     = r_head;
                        wdata     = r_rdata - SIZE_BITS'(r_left);
                        n_total   = (LW'(r_total) >= LW'(r_left))
                                    ? r_total - SIZE_BITS'(r_left) : '0;
                        n_left    = '0;
                        n_olast   = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_capacity  <= CAPACITY_RESET;
            r_leak_rate <= LEAK_RATE_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_BUCKET_CAPACITY) begin
                    r_capacity <= i_cfg.data;
                end else if (i_cfg.index == CFG_LEAK_RATE) begin
                    r_leak_rate <= i_cfg.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_okind   <= n_okind;
        r_oamount <= n_oamount;
        r_olast   <= n_olast;
        if (in_accept) begin
            r_mode  <= i_in.mode;
            r_psize <= SIZE_BITS'(i_in.packet_size);
            r_left  <= r_leak_rate;
        end else begin
            r_left <= n_left;
        end
    end

    // size queue storage, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[r_head];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we && rd_en))
        else $error("memory write during head read");

    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> ($past(r_state) == ST_RD || $past(r_state) == ST_EVAL))
        else $error("evaluate without read data");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL && r_mode && emit && r_count == CNTW'(1))
        |=> (r_count == '0 && r_head == '0 && r_tail == '0 && r_total == '0))
        else $error("flush left queue state behind");

endmodule
